/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers for the RTL; included by softmax_cross_entropy_backprop.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SCE_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Antecedent now, consequent in the next cycle, disabled during reset.
`define SCE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/sce_pkg.sv */
// ----------------------------------------------------------------------------
// sce_pkg
// Types and fixed widths for the softmax cross-entropy gradient block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sce_pkg;

  localparam int W_W       = 16;           // weight / prediction, Q3.12
  localparam int ERR_W     = 17;           // output error, Q4.12
  localparam int PROD_W    = W_W + ERR_W;  // Q.24 product
  localparam int ACC_W     = PROD_W + 5;   // headroom for up to 16 classes (+1 spare)
  localparam int FRAC_BITS = 12;
  localparam int SUM_W     = ACC_W - FRAC_BITS;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_PRED = 1'b1;

  localparam logic signed [ERR_W-1:0] Q_ONE    = 17'sd4096;
  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(2048);

  // Control that travels alongside each operand pair into the MAC.
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctl_t;

endpackage

/* rtl/softmax_cross_entropy_backprop.sv */
// Throughput: while idle, loads and non-final predictions take one request per
// cycle; the final prediction starts a run, during which requests stall.
// A run emits NUM_ROWS results in turn, paced by the single shared
// multiply-accumulate and the one read port of the weight store.
// Reset (rst, synchronous) clears the sequencer, MAC control and output valid
// only; the weight store and error vector hold whatever was written, no clearing pass.
// ----------------------------------------------------------------------------
// softmax_cross_entropy_backprop
// Backward pass of softmax with sparse categorical cross-entropy, Q3.12.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module softmax_cross_entropy_backprop import sce_pkg::*; #(
  parameter int NUM_ROWS    = 32,
  parameter int NUM_CLASSES = 10
) (
  input  logic              clk,
  input  logic              rst,
  // request channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              cmd,
  input  logic [5:0]        row_index,
  input  logic [3:0]        class_index,
  input  logic signed [15:0] sample_value,
  input  logic [3:0]        true_label,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic signed [15:0] grad_value,
  output logic [5:0]        grad_index,
  output logic              last_result,
  output logic              clipped
);

  localparam int STORE_DEPTH = NUM_ROWS * NUM_CLASSES;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CLS_W       = $clog2(NUM_CLASSES);
  localparam int ROW_W       = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
  localparam logic [CLS_W-1:0] CLS_LAST = CLS_W'(NUM_CLASSES - 1);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(NUM_ROWS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,   // taking loads and predictions
    ST_RUN,    // issuing one row of weight/error pairs
    ST_WAIT,   // MAC pipeline draining
    ST_OUT     // handing the row sum to the output register
  } state_t;

  state_t state;

  // --------------------------------------------------------------------------
  // Request decode
  // --------------------------------------------------------------------------
  logic                    in_acc;
  logic                    load_ok;
  logic                    pred_ok;
  logic                    pred_last;
  logic [CLS_W-1:0]        in_cls;
  logic [ADDR_W-1:0]       wr_addr;
  logic signed [ERR_W-1:0] err_new;

  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign in_cls   = class_index[CLS_W-1:0];

  // out-of-range loads and predictions are dropped
  assign load_ok   = in_acc && (cmd == CMD_LOAD) &&
                     (32'(row_index) < NUM_ROWS) && (32'(class_index) < NUM_CLASSES);
  assign pred_ok   = in_acc && (cmd == CMD_PRED) && (32'(class_index) < NUM_CLASSES);
  assign pred_last = pred_ok && (in_cls == CLS_LAST);

  // row-major: row * NUM_CLASSES + class
  assign wr_addr = ADDR_W'(32'(row_index) * NUM_CLASSES + 32'(class_index));

  // one-hot term only for the labeled class; a label out of range never matches
  assign err_new = (true_label == class_index) ? ERR_W'(sample_value) - Q_ONE
                                               : ERR_W'(sample_value);

  // --------------------------------------------------------------------------
  // Error vector: written by predictions, read once per issue slot
  // --------------------------------------------------------------------------
  logic signed [ERR_W-1:0] err_vec [NUM_CLASSES];
  logic signed [ERR_W-1:0] err_q;

  // --------------------------------------------------------------------------
  // Sequencer counters and issue control
  // --------------------------------------------------------------------------
  logic [ADDR_W-1:0] rd_addr;
  logic [CLS_W-1:0]  cls_cnt;
  logic [ROW_W-1:0]  row_cnt;
  logic              rd_en;
  mac_ctl_t          iss;

  assign rd_en = (state == ST_RUN);

  // MAC results
  logic signed [W_W-1:0] mac_sum;
  logic                  mac_clip;
  logic                  mac_done;
  logic                  out_free;

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (pred_ok) begin
      err_vec[in_cls] <= err_new;
    end
    if (state == ST_RUN) begin
      err_q <= err_vec[cls_cnt];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rd_addr   <= '0;
      cls_cnt   <= '0;
      row_cnt   <= '0;
      iss       <= '0;
      out_valid <= 1'b0;
    end else begin
      iss <= '0;
      // load a new result when emitting, else drop the one just taken
      if ((state == ST_OUT) && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (pred_last) begin
            rd_addr <= '0;
            cls_cnt <= '0;
            row_cnt <= '0;
            state   <= ST_RUN;
          end
        end
        ST_RUN: begin
          iss.valid <= 1'b1;
          iss.first <= (cls_cnt == '0);
          iss.last  <= (cls_cnt == CLS_LAST);
          rd_addr   <= rd_addr + ADDR_W'(1);
          if (cls_cnt == CLS_LAST) begin
            cls_cnt <= '0;
            state   <= ST_WAIT;
          end else begin
            cls_cnt <= cls_cnt + CLS_W'(1);
          end
        end
        ST_WAIT: begin
          if (mac_done) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          // accumulator holds its value until the output register frees up
          if (out_free) begin
            grad_value  <= mac_sum;
            clipped     <= mac_clip;
            grad_index  <= 6'(row_cnt);
            last_result <= (row_cnt == ROW_LAST);
            if (row_cnt == ROW_LAST) begin
              state <= ST_IDLE;
            end else begin
              row_cnt <= row_cnt + ROW_W'(1);
              state   <= ST_RUN;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Datapath units
  // --------------------------------------------------------------------------
  logic signed [W_W-1:0] rd_data;

  sce_wstore #(
    .DEPTH  (STORE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_wstore (
    .clk     (clk),
    .wr_en   (load_ok),
    .wr_addr (wr_addr),
    .wr_data (sample_value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // weight and error both land in the cycle after issue, together with iss
  sce_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctl  (iss),
    .op_w (rd_data),
    .op_e (err_q),
    .sum  (mac_sum),
    .clip (mac_clip),
    .done (mac_done)
  );

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `SCE_ASSERT(a_done_in_wait, clk, rst, mac_done |-> (state == ST_WAIT), "MAC done outside drain")
  `SCE_ASSERT(a_rise_from_out, clk, rst, $rose(out_valid) |-> ($past(state) == ST_OUT), "result not from emit state")
  `SCE_ASSERT(a_last_index, clk, rst, (out_valid && last_result) |-> (grad_index == 6'(NUM_ROWS - 1)), "last marker on wrong index")
  `SCE_ASSERT_NEXT(a_run_to_wait, clk, rst, (state == ST_RUN) && (cls_cnt == CLS_LAST), (state == ST_WAIT) && iss.valid && iss.last, "row issue did not close")

endmodule

/* rtl/sce_wstore.sv */
// ----------------------------------------------------------------------------
// sce_wstore
// Weight store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sce_wstore import sce_pkg::*; #(
  parameter int DEPTH  = 320,
  parameter int ADDR_W = 9
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [ADDR_W-1:0]     wr_addr,
  input  logic signed [W_W-1:0] wr_data,
  input  logic                  rd_en,
  input  logic [ADDR_W-1:0]     rd_addr,
  output logic signed [W_W-1:0] rd_data
);

  logic signed [W_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/sce_mac.sv */
// ----------------------------------------------------------------------------
// sce_mac
// Shared multiply-accumulate: registered product, then accumulator, with
// round-to-nearest and saturation of the sum output to Q3.12.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sce_mac import sce_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  mac_ctl_t                ctl,
  input  logic signed [W_W-1:0]   op_w,
  input  logic signed [ERR_W-1:0] op_e,
  output logic signed [W_W-1:0]   sum,
  output logic                    clip,
  output logic                    done
);

  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(32767);
  localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-32768);

  mac_ctl_t                  p_ctl;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   rnd;
  logic signed [SUM_W-1:0]   shifted;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_ctl <= '0;
      done  <= 1'b0;
    end else begin
      p_ctl <= ctl;
      done  <= p_ctl.valid && p_ctl.last;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.valid) begin
      prod <= op_w * op_e;
    end
    if (p_ctl.valid) begin
      acc <= p_ctl.first ? ACC_W'(prod) : acc + ACC_W'(prod);
    end
  end

  // floor((acc + half) / 4096) is an arithmetic drop of the fraction bits
  assign rnd     = acc + RND_HALF;
  assign shifted = rnd[ACC_W-1:FRAC_BITS];

  always_comb begin
    if (shifted > SAT_HI) begin
      sum  = W_W'(SAT_HI);
      clip = 1'b1;
    end else if (shifted < SAT_LO) begin
      sum  = W_W'(SAT_LO);
      clip = 1'b1;
    end else begin
      sum  = shifted[W_W-1:0];
      clip = 1'b0;
    end
  end

endmodule

/* bench/softmax_cross_entropy_backprop_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// softmax_cross_entropy_backprop_test
// Self-checking bench for the softmax cross-entropy gradient block: fills the
// weight store, runs directed and random prediction sequences under random
// request gaps and result back-pressure, and checks every input error that
// comes out against a bit-accurate prediction kept in a small scoreboard.
// ----------------------------------------------------------------------------

module softmax_cross_entropy_backprop_test;
  import sce_pkg::*;

  localparam int N_IN         = 32;
  localparam int N_CLS        = 10;
  localparam int RANDOM_ITEMS = 125;   // on top of the store fill and directed part
  localparam int DRAIN_CYCLES = 4 * (N_CLS + 5) + 64;

  typedef struct packed {
    logic signed [15:0] value;
    logic [5:0]         index;
    logic               last;
    logic               clip;
  } grad_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: mirrors the weight store and the output-error vector, turns
  // every accepted request into the input errors it should produce, and
  // checks the results in arrival order.
  // --------------------------------------------------------------------------
  class grad_tracker;
    logic signed [15:0] weight_mem [N_IN*N_CLS];
    logic signed [16:0] class_err [N_CLS];
    grad_result_t       pending_grads [$];
    int                 mismatches;
    int                 grads_seen;
    int                 clip_seen;
    int                 loads_seen;
    int                 preds_seen;

    function new();
      mismatches = 0;
      grads_seen = 0;
      clip_seen  = 0;
      loads_seen = 0;
      preds_seen = 0;
    endfunction

    function int outstanding();
      return pending_grads.size();
    endfunction

    function void absorb_request(logic c, logic [5:0] r, logic [3:0] k,
                                 logic signed [15:0] v, logic [3:0] lbl);
      longint       acc;
      longint       rounded;
      logic signed [16:0] e;
      grad_result_t g;
      if (c == CMD_LOAD) begin
        loads_seen++;
        if (r < N_IN && k < N_CLS) weight_mem[r*N_CLS + k] = v;
        return;
      end
      preds_seen++;
      if (k >= N_CLS) return;
      e = v;
      if (lbl == k) e = e - Q_ONE;
      class_err[k] = e;
      if (k != N_CLS - 1) return;
      for (int i = 0; i < N_IN; i++) begin
        acc = 0;
        for (int j = 0; j < N_CLS; j++)
          acc += longint'(weight_mem[i*N_CLS + j]) * longint'(class_err[j]);
        // Q.24 -> Q3.12, round half up, then clamp
        rounded = (acc + 2048) >>> FRAC_BITS;
        g.clip = 1'b0;
        if (rounded > 32767) begin
          rounded = 32767;
          g.clip  = 1'b1;
        end else if (rounded < -32768) begin
          rounded = -32768;
          g.clip  = 1'b1;
        end
        g.value = 16'(rounded);
        g.index = 6'(i);
        g.last  = (i == N_IN - 1);
        if (g.clip) clip_seen++;
        pending_grads.push_back(g);
      end
    endfunction

    function void compare_grad(logic signed [15:0] v, logic [5:0] idx, logic l, logic c);
      grad_result_t want;
      grads_seen++;
      if (pending_grads.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: value %0d index %0d last %0b clip %0b",
                   v, idx, l, c);
        return;
      end
      want = pending_grads.pop_front();
      if (v !== want.value || idx !== want.index || l !== want.last || c !== want.clip) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch at result %0d: want value %0d index %0d last %0b clip %0b",
                   grads_seen, want.value, want.index, want.last, want.clip);
          $display("  got value %0d index %0d last %0b clip %0b", v, idx, l, c);
        end
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Block ports, all inputs driven to known values from time zero
  // --------------------------------------------------------------------------
  logic               clk          = 1'b0;
  logic               rst          = 1'b1;
  logic               in_valid     = 1'b0;
  logic               in_stall;
  logic               cmd          = CMD_LOAD;
  logic [5:0]         row_index    = '0;
  logic [3:0]         class_index  = '0;
  logic signed [15:0] sample_value = '0;
  logic [3:0]         true_label   = '0;
  logic               out_valid;
  logic               out_stall    = 1'b0;
  logic signed [15:0] grad_value;
  logic [5:0]         grad_index;
  logic               last_result;
  logic               clipped;

  // When set, neither side idles: back-to-back requests, results never stalled.
  bit steady = 1'b0;

  grad_tracker tracker = new();

  softmax_cross_entropy_backprop #(
    .NUM_ROWS    (N_IN),
    .NUM_CLASSES (N_CLS)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .row_index    (row_index),
    .class_index  (class_index),
    .sample_value (sample_value),
    .true_label   (true_label),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .grad_value   (grad_value),
    .grad_index   (grad_index),
    .last_result  (last_result),
    .clipped      (clipped)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Idle length: mostly short, now and then a long pause.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(0, 3);
    if (roll < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Q3.12 value with a bias toward the rails, zero and tiny magnitudes.
  function automatic logic signed [15:0] rand_sample();
    int pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) return 16'sh7FFF;
    if (pick == 1) return 16'sh8000;
    if (pick == 2) return 16'sd0;
    if (pick == 3) return 16'(int'($urandom_range(0, 32)) - 16);
    return 16'($urandom());
  endfunction

  // Drive one request and hold it until the block takes it. Called right
  // after a rising edge; returns at the edge that accepted it (or after the
  // idle gap that follows), so the next call can drive again without a
  // second assignment to in_valid in the same step.
  task automatic send_request(input logic c, input logic [5:0] r, input logic [3:0] k,
                              input logic signed [15:0] v, input logic [3:0] lbl);
    int gap;
    in_valid     <= 1'b1;
    cmd          <= c;
    row_index    <= r;
    class_index  <= k;
    sample_value <= v;
    true_label   <= lbl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.absorb_request(c, r, k, v, lbl);
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // A request the block must drop: load outside the store, or a prediction
  // for a class that does not exist.
  task automatic send_noise();
    int pick;
    pick = $urandom_range(0, 2);
    if (pick == 0)
      send_request(CMD_LOAD, 6'($urandom_range(N_IN, 63)), 4'($urandom()), rand_sample(),
                   4'($urandom()));
    else if (pick == 1)
      send_request(CMD_LOAD, 6'($urandom_range(0, N_IN - 1)), 4'($urandom_range(N_CLS, 15)),
                   rand_sample(), 4'($urandom()));
    else
      send_request(CMD_PRED, 6'($urandom()), 4'($urandom_range(N_CLS, 15)), rand_sample(),
                   4'($urandom()));
  endtask

  // --------------------------------------------------------------------------
  // Result side: random back-pressure, with quiet stretches
  // --------------------------------------------------------------------------
  initial begin
    int n;
    forever begin
      out_stall <= 1'b0;
      repeat (1 + $urandom_range(0, 7)) @(posedge clk);
      n = steady ? 0 : pick_gap();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
    end
  end

  // All bench drives are nonblocking, so values read here are the ones the
  // block saw at this edge.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      tracker.compare_grad(grad_value, grad_index, last_result, clipped);
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int                 useful;
    int                 n;
    bit                 broken;
    logic [3:0]         lbl;
    logic signed [15:0] w;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Fill every weight entry first so that no emission reads an unloaded
    // one. Row 0 at the positive rail, row 1 at the negative rail, row 2 a
    // single LSB on class 0 to expose the rounding of exact halves.
    for (int r = 0; r < N_IN; r++) begin
      for (int k = 0; k < N_CLS; k++) begin
        case (r)
          0:       w = 16'sh7FFF;
          1:       w = 16'sh8000;
          2:       w = (k == 0) ? 16'sd1 : 16'sd0;
          default: w = rand_sample();
        endcase
        send_request(CMD_LOAD, 6'(r), 4'(k), w, 4'($urandom()));
      end
    end

    // Directed run: all predictions at max, label 0. Rows 0/1 saturate.
    for (int k = 0; k < N_CLS; k++)
      send_request(CMD_PRED, 6'd0, 4'(k), 16'sh7FFF, 4'd0);

    // Directed run: predictions at min with the label on the last class,
    // giving the most negative output error; class 0 makes row 2 round +0.5.
    for (int k = 0; k < N_CLS; k++)
      send_request(CMD_PRED, 6'd63, 4'(k), (k == 0) ? 16'sd2048 : 16'sh8000,
                   4'(N_CLS - 1));

    // Partial run: only classes 0 and last are refreshed, the rest keep their
    // errors. Label out of range, so no one-hot term. Row 2 now sees -0.5,
    // which rounds up to zero. Dropped loads and predictions in between, plus
    // one real reload that the emission must pick up.
    send_request(CMD_PRED, 6'd0, 4'd0, -16'sd2048, 4'd15);
    send_request(CMD_PRED, 6'd0, 4'(N_CLS + 2), 16'sh7FFF, 4'd0);
    send_request(CMD_LOAD, 6'd40, 4'd3, 16'sh7FFF, 4'd0);
    send_request(CMD_LOAD, 6'd5, 4'(N_CLS + 1), 16'sh8000, 4'd0);
    send_request(CMD_LOAD, 6'd3, 4'(N_CLS - 1), 16'sh8000, 4'd0);
    send_request(CMD_PRED, 6'd0, 4'(N_CLS - 1), 16'sh4000, 4'd15);

    // Random part: mostly prediction sequences in ascending class order with
    // random skips, some broken off before the last class, mixed with weight
    // reloads and requests the block has to drop.
    useful = 0;
    while (useful < RANDOM_ITEMS) begin
      steady = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 99) < 65) begin
        lbl = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(N_CLS, 15))
                                          : 4'($urandom_range(0, N_CLS - 1));
        broken = ($urandom_range(0, 9) == 0);
        for (int k = 0; k < N_CLS; k++) begin
          if (k == N_CLS - 1 ? !broken : ($urandom_range(0, 3) != 0)) begin
            if ($urandom_range(0, 11) == 0) send_noise();
            send_request(CMD_PRED, 6'($urandom()), 4'(k), rand_sample(), lbl);
            useful++;
          end
        end
      end else begin
        n = $urandom_range(1, 6);
        repeat (n) begin
          if ($urandom_range(0, 4) == 0) send_noise();
          send_request(CMD_LOAD, 6'($urandom_range(0, N_IN - 1)),
                       4'($urandom_range(0, N_CLS - 1)), rand_sample(), 4'($urandom()));
          useful++;
        end
      end
    end

    steady = 1'b0;
    in_valid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d requests (%0d loads, %0d predictions) and %0d input errors,",
             tracker.loads_seen + tracker.preds_seen, tracker.loads_seen,
             tracker.preds_seen, tracker.grads_seen);
    $display("%0d of them saturated; %0d mismatches.", tracker.clip_seen,
             tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #40000000;
    $display("watchdog expired with %0d results outstanding", tracker.outstanding());
    $display("TEST FAILED");
    $finish;
  end

endmodule
